### rtl/e2q_pkg.sv
`default_nettype none

package e2q_pkg;

   // Default build settings.
   localparam int CORDIC_STEPS_DEF         = 24;
   localparam int RESULT_FRACTION_BITS_DEF = 30;

   // Field and datapath widths.
   localparam int ANGLE_W = 24;
   localparam int QUAT_W  = 32;
   localparam int XY_W    = 34;
   localparam int Z_W     = 36;
   localparam int Q_W     = 33;
   localparam int ROOT_W  = 32;
   localparam int NORM_W  = 64;
   localparam int INV_W   = 61;
   localparam int REM_W   = 33;
   localparam int LANES   = 3;
   localparam int SQRT_STEPS = NORM_W / 2;

   // Angle reduction, half angles in degrees * 512.
   localparam int HALF_TURN   = 184320;
   localparam int HALF_PERIOD = 92160;
   localparam int QUARTER     = 46080;

   // CORDIC start vector: the inverse CORDIC gain with 30 fraction bits.
   localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

   // One angle lane as it moves down the CORDIC row.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } lane_type;

   typedef lane_type [LANES-1:0] lanes_type;

   typedef logic signed [Q_W-1:0] comp_type;
   typedef comp_type [3:0] quat_type;

   // atan(2^-i) in degrees * 2^24.
   function automatic longint atan_entry(input int idx);
      longint v;
      case (idx)
         0:  v = 754974720;
         1:  v = 445687602;
         2:  v = 235489089;
         3:  v = 119537938;
         4:  v = 60000934;
         5:  v = 30029717;
         6:  v = 15018523;
         7:  v = 7509720;
         8:  v = 3754917;
         9:  v = 1877466;
         10: v = 938734;
         11: v = 469367;
         12: v = 234683;
         13: v = 117342;
         14: v = 58671;
         15: v = 29335;
         16: v = 14668;
         17: v = 7334;
         18: v = 3667;
         19: v = 1833;
         20: v = 917;
         21: v = 458;
         22: v = 229;
         23: v = 115;
         24: v = 57;
         25: v = 29;
         26: v = 14;
         27: v = 7;
         28: v = 4;
         29: v = 2;
         30: v = 1;
         default: v = 0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/e2q_cordic_cell.sv
`default_nettype none

// One CORDIC rotation step applied to all three angle lanes.
module e2q_cordic_cell import e2q_pkg::*; #(
   parameter int STEP = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enable,
   input  wire logic      in_valid,
   input  wire lanes_type in_lanes,
   output logic           out_valid,
   output lanes_type      out_lanes
);

   localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_entry(STEP));

   logic      valid_ff;
   lanes_type lanes_ff, lanes_in;

   // Rotate towards zero residual angle.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lanes_in[k].flip = in_lanes[k].flip;
         if (!in_lanes[k].z[Z_W-1]) begin
            lanes_in[k].x = in_lanes[k].x - (in_lanes[k].y >>> STEP);
            lanes_in[k].y = in_lanes[k].y + (in_lanes[k].x >>> STEP);
            lanes_in[k].z = in_lanes[k].z - ATAN;
         end else begin
            lanes_in[k].x = in_lanes[k].x + (in_lanes[k].y >>> STEP);
            lanes_in[k].y = in_lanes[k].y - (in_lanes[k].x >>> STEP);
            lanes_in[k].z = in_lanes[k].z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;

endmodule

`default_nettype wire

### rtl/e2q_sqrt_cell.sv
`default_nettype none

// One digit of the integer square root of the squared norm.
module e2q_sqrt_cell import e2q_pkg::*; #(
   parameter int STEP = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [NORM_W-1:0] in_rem,
   input  wire logic [NORM_W-1:0] in_root,
   input  wire quat_type          in_quat,
   output logic                   out_valid,
   output logic [NORM_W-1:0]      out_rem,
   output logic [NORM_W-1:0]      out_root,
   output quat_type               out_quat
);

   localparam logic [NORM_W-1:0] TRIAL_BIT = NORM_W'(1) << (NORM_W - 2 - 2 * STEP);

   logic              valid_ff;
   logic [NORM_W-1:0] rem_ff, rem_in;
   logic [NORM_W-1:0] root_ff, root_in;
   logic [NORM_W:0]   trial;
   quat_type          quat_ff;

   // Subtract the trial square where it fits.
   always_comb begin
      trial = {1'b0, in_root} + {1'b0, TRIAL_BIT};
      if ({1'b0, in_rem} >= trial) begin
         rem_in  = in_rem - trial[NORM_W-1:0];
         root_in = (in_root >> 1) + TRIAL_BIT;
      end else begin
         rem_in  = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         quat_ff <= in_quat;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_quat  = quat_ff;

endmodule

`default_nettype wire

### rtl/e2q_div_cell.sv
`default_nettype none

// One quotient bit of the reciprocal 2^60 / root, restoring division.
module e2q_div_cell import e2q_pkg::*; #(
   parameter int BIT = INV_W - 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [REM_W-1:0]  in_rem,
   input  wire logic [INV_W-1:0]  in_quot,
   input  wire logic [ROOT_W-1:0] in_root,
   input  wire quat_type          in_quat,
   output logic                   out_valid,
   output logic [REM_W-1:0]       out_rem,
   output logic [INV_W-1:0]       out_quot,
   output logic [ROOT_W-1:0]      out_root,
   output quat_type               out_quat
);

   // The dividend is a single one in its top bit.
   localparam logic DIVIDEND_BIT = (BIT == INV_W - 1);

   logic              valid_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [INV_W-1:0]  quot_ff, quot_in;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  shifted;
   quat_type          quat_ff;

   // Shift in the next dividend bit and subtract the divisor where it fits.
   always_comb begin
      shifted = {in_rem[REM_W-2:0], DIVIDEND_BIT};
      quot_in = in_quot;
      if (shifted >= {1'b0, in_root}) begin
         rem_in       = shifted - {1'b0, in_root};
         quot_in[BIT] = 1'b1;
      end else begin
         rem_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         root_ff <= in_root;
         quat_ff <= in_quat;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;
   assign out_root  = root_ff;
   assign out_quat  = quat_ff;

endmodule

`default_nettype wire

### rtl/euler_to_quaternion.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  roll_deg, pitch_deg, yaw_deg (s24, 8 frac)
// rsp_      out        rsp_valid / rsp_ready  quat_w, quat_x, quat_y, quat_z (s32)
//
// One item is accepted per cycle while the output is not stalled; the pipeline length is set by
// the CORDIC row, the 32-cell square root row and the 61-cell reciprocal row.
// Synchronous active-high reset clears only the valid bits of every stage.
// The whole pipeline advances whenever the output register is empty or taken, so
// a stall on rsp_ready holds every stage and drops req_ready in the same cycle.
module euler_to_quaternion import e2q_pkg::*; #(
   parameter int CORDIC_STEPS         = CORDIC_STEPS_DEF,
   parameter int RESULT_FRACTION_BITS = RESULT_FRACTION_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [ANGLE_W-1:0] req_roll_deg,
   input  wire logic signed [ANGLE_W-1:0] req_pitch_deg,
   input  wire logic signed [ANGLE_W-1:0] req_yaw_deg,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [QUAT_W-1:0]       rsp_quat_w,
   output logic signed [QUAT_W-1:0]       rsp_quat_x,
   output logic signed [QUAT_W-1:0]       rsp_quat_y,
   output logic signed [QUAT_W-1:0]       rsp_quat_z
);

   localparam int     SHIFT  = 30 - RESULT_FRACTION_BITS;
   localparam longint ROUND  = (SHIFT > 0) ? (64'sd1 <<< (SHIFT - 1)) : 64'sd0;
   localparam int     WIDE_W = 66;
   localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(64'sd1 <<< RESULT_FRACTION_BITS);

   // Fixed-point multiply with 30 fraction bits, rounded half up.
   function automatic logic signed [XY_W-1:0] mulq(input logic signed [XY_W-1:0] a,
                                                   input logic signed [XY_W-1:0] b);
      logic signed [2*XY_W-1:0] p;
      p = a * b + (2*XY_W)'(64'sd1 <<< 29);
      return XY_W'(p >>> 30);
   endfunction

   // Reduce a half angle into [-90, 90] degrees and form the CORDIC start lane.
   function automatic lane_type reduce(input logic [12:0] a, input logic [7:0] qe,
                                       input logic [11:0] low);
      logic [12:0]        rr;
      logic [5:0]         r;
      logic signed [18:0] hs;
      lane_type           l;
      rr = a - 13'({5'b0, qe} * 13'd45);
      r  = (rr >= 13'd45) ? 6'(rr - 13'd45) : 6'(rr);
      hs = signed'({1'b0, r, low});
      if (hs >= HALF_PERIOD) begin
         hs = 19'(hs - HALF_TURN);
      end
      l.flip = 1'b0;
      if (hs > QUARTER) begin
         hs     = 19'(hs - HALF_PERIOD);
         l.flip = 1'b1;
      end else if (hs < -QUARTER) begin
         hs     = 19'(hs + HALF_PERIOD);
         l.flip = 1'b1;
      end
      l.x = CORDIC_X0;
      l.y = '0;
      l.z = Z_W'(hs) <<< 15;
      return l;
   endfunction

   logic rsp_valid_ff;
   logic advance;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   logic signed [ANGLE_W-1:0] angle [LANES];
   assign angle[0] = req_roll_deg;
   assign angle[1] = req_pitch_deg;
   assign angle[2] = req_yaw_deg;

   // First stage: offset to a positive value and estimate the quotient by 45 * 4096.
   logic [24:0] offs [LANES];
   logic [24:0] prod [LANES];
   logic        s1_valid_ff;
   logic [12:0] s1_a_ff [LANES];
   logic [7:0]  s1_qe_ff [LANES];
   logic [11:0] s1_low_ff [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         offs[k] = 25'({{2{angle[k][ANGLE_W-1]}}, angle[k]} + 26'd8478720);
         prod[k] = {12'b0, offs[k][24:12]} * 25'd2912;
      end
   end

   // Second stage: remainder correction and fold into the CORDIC range.
   logic      s2_valid_ff;
   lanes_type s2_lanes_ff, s2_lanes_in;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         s2_lanes_in[k] = reduce(s1_a_ff[k], s1_qe_ff[k], s1_low_ff[k]);
      end
   end

   // CORDIC row.
   lanes_type cl [CORDIC_STEPS+1];
   logic      cv [CORDIC_STEPS+1];
   assign cl[0] = s2_lanes_ff;
   assign cv[0] = s2_valid_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      e2q_cordic_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (cv[i]),
         .in_lanes  (cl[i]),
         .out_valid (cv[i+1]),
         .out_lanes (cl[i+1])
      );
   end

   // Third stage: undo the half-turn fold and form the yaw-pitch products.
   logic signed [XY_W-1:0] sn [LANES];
   logic signed [XY_W-1:0] cs [LANES];
   logic                   s3_valid_ff;
   logic signed [XY_W-1:0] s3_cycp_ff, s3_sysp_ff, s3_cysp_ff, s3_sycp_ff;
   logic signed [XY_W-1:0] s3_sr_ff, s3_cr_ff;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         sn[k] = cl[CORDIC_STEPS][k].flip ? -cl[CORDIC_STEPS][k].y : cl[CORDIC_STEPS][k].y;
         cs[k] = cl[CORDIC_STEPS][k].flip ? -cl[CORDIC_STEPS][k].x : cl[CORDIC_STEPS][k].x;
      end
   end

   // Fourth stage: products with the roll terms.
   logic                   s4_valid_ff;
   logic signed [XY_W-1:0] s4_m_ff [8];

   // Fifth stage: quaternion components.
   logic     s5_valid_ff;
   quat_type s5_quat_ff;

   // Sixth and seventh stages: squares and the squared norm.
   logic              s6_valid_ff;
   logic [NORM_W-1:0] s6_sq_ff [4];
   quat_type          s6_quat_ff;
   logic              s7_valid_ff;
   logic [NORM_W-1:0] s7_norm_ff;
   quat_type          s7_quat_ff;

   logic [2*Q_W-1:0]  sq_full [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sq_full[k] = (2*Q_W)'(s5_quat_ff[k]) * (2*Q_W)'(s5_quat_ff[k]);
      end
   end

   // Square root row.
   logic              sv [SQRT_STEPS+1];
   logic [NORM_W-1:0] srem [SQRT_STEPS+1];
   logic [NORM_W-1:0] sroot [SQRT_STEPS+1];
   quat_type          squat [SQRT_STEPS+1];
   assign sv[0]    = s7_valid_ff;
   assign srem[0]  = s7_norm_ff;
   assign sroot[0] = '0;
   assign squat[0] = s7_quat_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      e2q_sqrt_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (sv[i]),
         .in_rem    (srem[i]),
         .in_root   (sroot[i]),
         .in_quat   (squat[i]),
         .out_valid (sv[i+1]),
         .out_rem   (srem[i+1]),
         .out_root  (sroot[i+1]),
         .out_quat  (squat[i+1])
      );
   end

   // Reciprocal row.
   logic              dv [INV_W+1];
   logic [REM_W-1:0]  drem [INV_W+1];
   logic [INV_W-1:0]  dquot [INV_W+1];
   logic [ROOT_W-1:0] droot [INV_W+1];
   quat_type          dquat [INV_W+1];
   assign dv[0]    = sv[SQRT_STEPS];
   assign drem[0]  = '0;
   assign dquot[0] = '0;
   assign droot[0] = sroot[SQRT_STEPS][ROOT_W-1:0];
   assign dquat[0] = squat[SQRT_STEPS];

   for (genvar i = 0; i < INV_W; i++) begin : g_div
      e2q_div_cell #(.BIT(INV_W - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (dv[i]),
         .in_rem    (drem[i]),
         .in_quot   (dquot[i]),
         .in_root   (droot[i]),
         .in_quat   (dquat[i]),
         .out_valid (dv[i+1]),
         .out_rem   (drem[i+1]),
         .out_quot  (dquot[i+1]),
         .out_root  (droot[i+1]),
         .out_quat  (dquat[i+1])
      );
   end

   // Eighth stage: component times reciprocal, split into two partial products.
   logic                     s8_valid_ff;
   logic                     s8_zero_ff;
   logic signed [63:0]       s8_plo_ff [4];
   logic signed [64:0]       s8_phi_ff [4];
   logic [INV_W-1:0]         inv;
   assign inv = dquot[INV_W];

   // Output stage: recombine, round, clamp.
   logic signed [QUAT_W-1:0] rsp_quat_ff [4], rsp_quat_in [4];
   logic signed [WIDE_W-1:0] wide [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         wide[k] = WIDE_W'(s8_phi_ff[k])
                 + WIDE_W'((WIDE_W'(s8_plo_ff[k]) + WIDE_W'(64'sd1 <<< 29)) >>> 30);
         if (s8_zero_ff) begin
            wide[k] = (k == 0) ? WIDE_W'(64'sd1 <<< 30) : '0;
         end
         wide[k] = (wide[k] + WIDE_W'(ROUND)) >>> SHIFT;
         if (wide[k] > ONE) begin
            wide[k] = ONE;
         end else if (wide[k] < -ONE) begin
            wide[k] = -ONE;
         end
         rsp_quat_in[k] = QUAT_W'(wide[k]);
      end
   end

   // Stage registers, all held while the output is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= cv[CORDIC_STEPS];
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= dv[INV_W];
         rsp_valid_ff <= s8_valid_ff;
      end
      if (advance) begin
         for (int k = 0; k < LANES; k++) begin
            s1_a_ff[k]   <= offs[k][24:12];
            s1_qe_ff[k]  <= prod[k][24:17];
            s1_low_ff[k] <= offs[k][11:0];
         end
         s2_lanes_ff <= s2_lanes_in;
         s3_cycp_ff  <= mulq(cs[2], cs[1]);
         s3_sysp_ff  <= mulq(sn[2], sn[1]);
         s3_cysp_ff  <= mulq(cs[2], sn[1]);
         s3_sycp_ff  <= mulq(sn[2], cs[1]);
         s3_sr_ff    <= sn[0];
         s3_cr_ff    <= cs[0];
         s4_m_ff[0]  <= mulq(s3_cycp_ff, s3_cr_ff);
         s4_m_ff[1]  <= mulq(s3_sysp_ff, s3_sr_ff);
         s4_m_ff[2]  <= mulq(s3_cycp_ff, s3_sr_ff);
         s4_m_ff[3]  <= mulq(s3_sysp_ff, s3_cr_ff);
         s4_m_ff[4]  <= mulq(s3_cysp_ff, s3_cr_ff);
         s4_m_ff[5]  <= mulq(s3_sycp_ff, s3_sr_ff);
         s4_m_ff[6]  <= mulq(s3_sycp_ff, s3_cr_ff);
         s4_m_ff[7]  <= mulq(s3_cysp_ff, s3_sr_ff);
         s5_quat_ff[0] <= Q_W'(s4_m_ff[0] + s4_m_ff[1]);
         s5_quat_ff[1] <= Q_W'(s4_m_ff[2] - s4_m_ff[3]);
         s5_quat_ff[2] <= Q_W'(s4_m_ff[4] + s4_m_ff[5]);
         s5_quat_ff[3] <= Q_W'(s4_m_ff[6] - s4_m_ff[7]);
         for (int k = 0; k < 4; k++) begin
            s6_sq_ff[k] <= sq_full[k][NORM_W-1:0];
         end
         s6_quat_ff <= s5_quat_ff;
         s7_norm_ff <= s6_sq_ff[0] + s6_sq_ff[1] + s6_sq_ff[2] + s6_sq_ff[3];
         s7_quat_ff <= s6_quat_ff;
         s8_zero_ff <= (droot[INV_W] == '0);
         for (int k = 0; k < 4; k++) begin
            s8_plo_ff[k] <= 64'(dquat[INV_W][k]) * 64'($signed({1'b0, inv[29:0]}));
            s8_phi_ff[k] <= 65'(dquat[INV_W][k]) * 65'($signed({1'b0, inv[INV_W-1:30]}));
         end
         for (int k = 0; k < 4; k++) begin
            rsp_quat_ff[k] <= rsp_quat_in[k];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = rsp_quat_ff[0];
   assign rsp_quat_x = rsp_quat_ff[1];
   assign rsp_quat_y = rsp_quat_ff[2];
   assign rsp_quat_z = rsp_quat_ff[3];

   // An accepted item always enters the first stage.
   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item did not enter the pipeline");

   // A taken result with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !s8_valid_ff |=> !rsp_valid)
      else $error("result repeated after it was taken");

   // Results never leave the clamped range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (WIDE_W'(rsp_quat_w) <= ONE) && (WIDE_W'(rsp_quat_w) >= -ONE)
                 && (WIDE_W'(rsp_quat_x) <= ONE) && (WIDE_W'(rsp_quat_x) >= -ONE)
                 && (WIDE_W'(rsp_quat_y) <= ONE) && (WIDE_W'(rsp_quat_y) >= -ONE)
                 && (WIDE_W'(rsp_quat_z) <= ONE) && (WIDE_W'(rsp_quat_z) >= -ONE))
      else $error("quaternion component outside unit range");

endmodule

`default_nettype wire
